/* sv/hmdu_pkg.sv */
`timescale 1ns / 1ps

package hmdu_pkg;

	localparam int unsigned DataW = 32;
	localparam int unsigned CntW  = 5;
	localparam int unsigned AluW  = DataW + 2;

	localparam logic [DataW-1:0] HILO_RESET = 32'hDEAD_DEAD;
	localparam logic [CntW-1:0]  LAST_STEP  = CntW'(DataW - 1);

	typedef enum logic [2:0] {
		OP_MULT = 3'd0,
		OP_MULU = 3'd1,
		OP_DIV  = 3'd2,
		OP_DIVU = 3'd3,
		OP_MTHI = 3'd4,
		OP_MTLO = 3'd5,
		OP_MFHI = 3'd6,
		OP_MFLO = 3'd7
	} op_t;

	typedef struct packed {
		logic load;
		logic step;
		logic fix;
		logic emit;
	} cmd_t;

endpackage

/* sv/hmdu_alu.sv */
`timescale 1ns / 1ps

module hmdu_alu (
	input  logic [hmdu_pkg::AluW-1:0] x,
	input  logic [hmdu_pkg::AluW-1:0] y,
	input  logic                      sub,
	output logic [hmdu_pkg::AluW-1:0] s
);

	assign s = x + (sub ? ~y : y) + {{(hmdu_pkg::AluW-1){1'b0}}, sub};

endmodule

/* sv/hmdu_ctrl.sv */
`timescale 1ns / 1ps

module hmdu_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  hmdu_pkg::op_t        op,
	output logic                 s_tready,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output hmdu_pkg::cmd_t       cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_BUSY,
		ST_FIX,
		ST_DONE
	} state_t;

	state_t                        state_q;
	logic [hmdu_pkg::CntW-1:0]     cnt_q;
	logic                          slot_free;
	logic                          arith;

	assign s_tready  = (state_q == ST_IDLE);
	assign slot_free = !m_tvalid || m_tready;
	assign arith     = (op == hmdu_pkg::OP_MULT) || (op == hmdu_pkg::OP_MULU) ||
	                   (op == hmdu_pkg::OP_DIV)  || (op == hmdu_pkg::OP_DIVU);

	always_comb begin
		cmd.load = s_tvalid && (state_q == ST_IDLE);
		cmd.step = (state_q == ST_BUSY);
		cmd.fix  = (state_q == ST_FIX);
		cmd.emit = (state_q == ST_DONE) && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			m_tvalid <= 1'b0;
		end else begin
			if ((state_q == ST_DONE) && slot_free)
				m_tvalid <= 1'b1;
			else if (m_tready)
				m_tvalid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						cnt_q   <= hmdu_pkg::LAST_STEP;
						state_q <= arith ? ST_BUSY : ST_DONE;
					end
				end
				ST_BUSY: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0)
						state_q <= ST_FIX;
				end
				ST_FIX: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (slot_free)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* sv/hmdu_dp.sv */
`timescale 1ns / 1ps

module hmdu_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  hmdu_pkg::cmd_t                    cmd,
	input  hmdu_pkg::op_t                     op,
	input  logic [hmdu_pkg::DataW-1:0]        operand_a,
	input  logic [hmdu_pkg::DataW-1:0]        operand_b,
	output logic [3*hmdu_pkg::DataW-1:0]      tdata
);

	localparam int unsigned W = hmdu_pkg::DataW;

	logic [W-1:0]               hi_q;
	logic [W-1:0]               lo_q;
	logic [W-1:0]               opnd_q;
	logic [W-1:0]               rd_q;
	logic                       qneg_q;
	logic                       rneg_q;
	logic                       mul_q;
	logic [3*W-1:0]             tdata_q;

	logic                       sa;
	logic                       sb;
	logic [W-1:0]               ma;
	logic [W-1:0]               mb;
	logic                       is_arith;
	logic                       is_mul;
	logic [hmdu_pkg::AluW-1:0]  alu_x;
	logic [hmdu_pkg::AluW-1:0]  alu_y;
	logic [hmdu_pkg::AluW-1:0]  alu_s;
	logic [W:0]                 mul_next;
	logic [2*W-1:0]             prod_neg;

	assign is_mul   = (op == hmdu_pkg::OP_MULT) || (op == hmdu_pkg::OP_MULU);
	assign is_arith = is_mul || (op == hmdu_pkg::OP_DIV) || (op == hmdu_pkg::OP_DIVU);
	assign sa = ((op == hmdu_pkg::OP_MULT) || (op == hmdu_pkg::OP_DIV)) && operand_a[W-1];
	assign sb = ((op == hmdu_pkg::OP_MULT) || (op == hmdu_pkg::OP_DIV)) && operand_b[W-1];
	assign ma = sa ? (~operand_a + 1'b1) : operand_a;
	assign mb = sb ? (~operand_b + 1'b1) : operand_b;

	// shared adder: add for shift-add multiply, subtract for restoring divide
	assign alu_x = mul_q ? {2'b00, hi_q} : {1'b0, hi_q, lo_q[W-1]};
	assign alu_y = {2'b00, opnd_q};

	hmdu_alu u_alu (
		.x   (alu_x),
		.y   (alu_y),
		.sub (!mul_q),
		.s   (alu_s)
	);

	assign mul_next = lo_q[0] ? alu_s[W:0] : {1'b0, hi_q};
	assign prod_neg = ~{hi_q, lo_q} + 1'b1;
	assign tdata    = tdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hi_q <= hmdu_pkg::HILO_RESET;
			lo_q <= hmdu_pkg::HILO_RESET;
		end else if (cmd.load) begin
			if (is_arith) begin
				hi_q <= '0;
				lo_q <= ma;
			end else if (op == hmdu_pkg::OP_MTHI) begin
				hi_q <= operand_a;
			end else if (op == hmdu_pkg::OP_MTLO) begin
				lo_q <= operand_a;
			end
		end else if (cmd.step) begin
			if (mul_q) begin
				hi_q <= mul_next[W:1];
				lo_q <= {mul_next[0], lo_q[W-1:1]};
			end else if (!alu_s[hmdu_pkg::AluW-1]) begin
				hi_q <= alu_s[W-1:0];
				lo_q <= {lo_q[W-2:0], 1'b1};
			end else begin
				hi_q <= alu_x[W-1:0];
				lo_q <= {lo_q[W-2:0], 1'b0};
			end
		end else if (cmd.fix) begin
			if (mul_q) begin
				if (qneg_q)
					{hi_q, lo_q} <= prod_neg;
			end else begin
				if (qneg_q)
					lo_q <= ~lo_q + 1'b1;
				if (rneg_q)
					hi_q <= ~hi_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			opnd_q <= mb;
			qneg_q <= sa ^ sb;
			rneg_q <= sa;
			mul_q  <= is_mul;
			case (op)
				hmdu_pkg::OP_MFHI: rd_q <= hi_q;
				hmdu_pkg::OP_MFLO: rd_q <= lo_q;
				default:           rd_q <= '0;
			endcase
		end
		if (cmd.emit)
			tdata_q <= {lo_q, hi_q, rd_q};
	end

endmodule

/* sv/hilo_multiply_divide_unit_core.sv */
`timescale 1ns / 1ps

// HI/LO multiply-divide unit. Each item carries an op and two 32-bit operands and
// returns one item with the read value (HI for mfhi, LO for mflo, else zero) and the
// HI and LO contents after the op. Multiply and divide run on one shared 34-bit
// adder, one bit per cycle over all 32 bits, then a sign fix-up step. Moves to and
// from HI/LO skip the adder and fix-up steps. One item is in work at a time; the
// finished item sits in an output register, so the next item is accepted while it
// waits. HI and LO reset to 0xDEADDEAD.
module hilo_multiply_divide_unit_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // operand_a [31:0], operand_b [63:32]
	input  logic [2:0]  s_tuser,   // op [2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata    // read_value [31:0], hi_value [63:32], lo_value [95:64]
);

	hmdu_pkg::cmd_t cmd;
	hmdu_pkg::op_t  op;

	assign op = hmdu_pkg::op_t'(s_tuser);

	hmdu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.op       (op),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	hmdu_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.op        (op),
		.operand_a (s_tdata[31:0]),
		.operand_b (s_tdata[63:32]),
		.tdata     (m_tdata)
	);

endmodule

/* sv/hmdu_checker.sv */
`timescale 1ns / 1ps

module hmdu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [95:0] m_tdata
);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("unit ready right after taking an item");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled output item changed");

	a_read_matches: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[31:0] != 32'd0) |->
			(m_tdata[31:0] == m_tdata[63:32]) || (m_tdata[31:0] == m_tdata[95:64]))
		else $error("read value is neither HI nor LO");

	a_out_needs_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("output item without an item in work");

endmodule

bind hilo_multiply_divide_unit_core hmdu_checker u_hmdu_checker (.*);
